// File: rtl/tlik_pkg.sv
`timescale 1ns / 1ps
package tlik_pkg;

  // Link length registers
  localparam int LINK_W = 15;
  localparam logic [LINK_W-1:0] UPPER_LEN_RESET = 15'd3277;
  localparam logic [LINK_W-1:0] LOWER_LEN_RESET = 15'd1638;

  typedef enum logic [0:0] {
    REG_UPPER_LEN = 1'b0,
    REG_LOWER_LEN = 1'b1
  } cfg_reg_t;

  // CORDIC datapath: vector width, angle width (Q30 radians)
  localparam int CW         = 52;
  localparam int ZW         = 34;
  localparam int NORM_EXP   = 40;
  localparam int NORM_STEPS = 7;
  localparam int CORDIC_FIXED_LAT = NORM_STEPS + 1;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // Output rounding and limits
  localparam int Q12_SHIFT     = 18;
  localparam int ELBOW_MAX     = 12868;
  localparam int SHOULDER_MAX  = 19302;

  // Truncated arctangent table, atan(2^-i) in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 34'sd843314856;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043836;
      3:  a = 34'sd133525158;
      4:  a = 34'sd67021686;
      5:  a = 34'sd33543515;
      6:  a = 34'sd16775850;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194282;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/tlik_cordic.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: atan2(in_y, in_x) in Q30 radians.
// Normalize, fold and micro-rotation registers advance while en is high.
module tlik_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tlik_pkg::CW-1:0]    in_y,
  input  logic signed [tlik_pkg::CW-1:0]    in_x,
  output logic signed [tlik_pkg::ZW-1:0]    angle
);
  import tlik_pkg::*;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  logic signed [CW-1:0] nx [0:NORM_STEPS];
  logic signed [CW-1:0] ny [0:NORM_STEPS];

  assign nx[0] = in_x;
  assign ny[0] = in_y;

  // Normalize: binary shift search until the larger magnitude reaches 2^40
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH  = (j < NORM_STEPS - 1) ? (32 >> j) : 1;
    localparam int LIM = (j < NORM_STEPS - 1) ? (NORM_EXP - SH) : NORM_EXP;
    logic [CW-1:0] ma, mb, m;
    assign ma = mag(nx[j]);
    assign mb = mag(ny[j]);
    assign m  = (ma > mb) ? ma : mb;
    always_ff @(posedge clk) begin
      if (en) begin
        if (m < (CW'(1) << LIM)) begin
          nx[j+1] <= nx[j] <<< SH;
          ny[j+1] <= ny[j] <<< SH;
        end else begin
          nx[j+1] <= nx[j];
          ny[j+1] <= ny[j];
        end
      end
    end
  end

  logic signed [CW-1:0] cx [0:STAGES];
  logic signed [CW-1:0] cy [0:STAGES];
  logic signed [ZW-1:0] cz [0:STAGES];

  // Fold left half plane into the right by a quarter turn
  always_ff @(posedge clk) begin
    if (en) begin
      if (nx[NORM_STEPS][CW-1]) begin
        if (!ny[NORM_STEPS][CW-1]) begin
          cx[0] <= ny[NORM_STEPS];
          cy[0] <= -nx[NORM_STEPS];
          cz[0] <= HALF_PI_Q30;
        end else begin
          cx[0] <= -ny[NORM_STEPS];
          cy[0] <= nx[NORM_STEPS];
          cz[0] <= -HALF_PI_Q30;
        end
      end else begin
        cx[0] <= nx[NORM_STEPS];
        cy[0] <= ny[NORM_STEPS];
        cz[0] <= '0;
      end
    end
  end

  // Micro-rotations, one per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][CW-1]) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - atan_q30(i);
        end
      end
    end
  end

  assign angle = cz[STAGES];

endmodule

// File: rtl/two_link_inverse_kinematics.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  target_x, target_y
// output    out        out_valid/out_stall shoulder_angle, elbow_angle, unreachable
// config    in         cfg_write          cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled; the pipeline depth is
// set by the 31-step square root chain and the CORDIC stages.
// rst (synchronous) clears valid bits and reloads the link lengths.
// A stalled output freezes the whole pipeline; in_stall follows it.
module two_link_inverse_kinematics #(
  parameter int COORD_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         target_x,
  input  logic signed [COORD_BITS-1:0]         target_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   shoulder_angle,
  output logic [13:0]                          elbow_angle,
  output logic                                 unreachable,
  input  logic                                 cfg_write,
  input  logic [0:0]                           cfg_index,
  input  logic [tlik_pkg::LINK_W-1:0]          cfg_data
);
  import tlik_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int RW    = 2 * CB;
  localparam int RW2   = (RW > 32) ? RW : 32;
  localparam int DW    = 2 * LINK_W + 1;
  localparam int SQW   = 2 * DW;
  localparam int STEPS = DW;
  localparam int CWD   = DW + 2;
  localparam int PW    = LINK_W + DW;
  localparam int TW    = PW + 4;
  localparam int LAT_C = CORDIC_FIXED_LAT + CORDIC_STAGES;
  localparam int SW    = ZW + 2;
  localparam int QW    = SW - Q12_SHIFT;

  logic adv;
  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;

  // Configuration registers
  logic [LINK_W-1:0] upper_len, lower_len;
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= UPPER_LEN_RESET;
      lower_len <= LOWER_LEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UPPER_LEN: upper_len <= cfg_data;
        REG_LOWER_LEN: lower_len <= cfg_data;
      endcase
    end
  end

  // Link-derived products, refreshed every cycle
  logic [2*LINK_W-1:0] l1sq, l2sq, l12, difsq;
  logic [2*LINK_W+1:0] sumsq;
  logic [LINK_W:0]     lsum;
  logic [LINK_W-1:0]   ldif;
  assign lsum = {1'b0, upper_len} + {1'b0, lower_len};
  assign ldif = (upper_len > lower_len) ? (upper_len - lower_len) : (lower_len - upper_len);
  always_ff @(posedge clk) begin
    l1sq  <= upper_len * upper_len;
    l2sq  <= lower_len * lower_len;
    l12   <= upper_len * lower_len;
    sumsq <= (2*LINK_W+2)'(lsum) * (2*LINK_W+2)'(lsum);
    difsq <= ldif * ldif;
  end

  // Stage 1: squares of coordinate magnitudes
  logic [CB-1:0] ax_in, ay_in;
  assign ax_in = target_x[CB-1] ? CB'(-target_x) : CB'(target_x);
  assign ay_in = target_y[CB-1] ? CB'(-target_y) : CB'(target_y);

  logic v1, v2, v3, v4, v5;
  logic [RW-1:0] ax2, ay2, r2;
  logic signed [CB-1:0] x1, y1, x2, y2, x3, y3, x4, y4, x5, y5;
  always_ff @(posedge clk) begin
    if (adv) begin
      ax2 <= RW'(ax_in) * RW'(ax_in);
      ay2 <= RW'(ay_in) * RW'(ay_in);
      x1  <= target_x;
      y1  <= target_y;
    end
  end

  // Stage 2: squared reach
  always_ff @(posedge clk) begin
    if (adv) begin
      r2 <= ax2 + ay2;
      x2 <= x1;
      y2 <= y1;
    end
  end

  // Stage 3: annulus test, law of cosines terms
  logic [RW2-1:0] r2e;
  logic [RW2:0]   cdiff;
  logic           unr3, unr4, unr5;
  logic signed [CWD-1:0] c3, c4, c5;
  logic [DW-1:0]  d3;
  assign r2e   = RW2'(r2);
  assign cdiff = {1'b0, r2e} - (RW2+1)'(l1sq) - (RW2+1)'(l2sq);
  always_ff @(posedge clk) begin
    if (adv) begin
      unr3 <= (upper_len == '0) || (lower_len == '0) || (r2 == '0) ||
              (r2e > RW2'(sumsq)) || (r2e < RW2'(difsq));
      c3   <= signed'(CWD'(cdiff));
      d3   <= {l12, 1'b0};
      x3   <= x2;
      y3   <= y2;
    end
  end

  // Stage 4: products for the radicand and the psi cosine term
  logic [DW-1:0]  cm;
  logic [SQW-1:0] csq4, dsq4, rad5;
  logic [PW-1:0]  l1d4;
  logic signed [TW-1:0] l2c4, t5, l2s_ext, c3_ext;
  assign cm      = c3[CWD-1] ? DW'(-c3) : DW'(c3);
  assign l2s_ext = TW'(signed'({1'b0, lower_len}));
  assign c3_ext  = TW'(c3);
  always_ff @(posedge clk) begin
    if (adv) begin
      csq4 <= SQW'(cm) * SQW'(cm);
      dsq4 <= SQW'(d3) * SQW'(d3);
      l1d4 <= PW'(upper_len) * PW'(d3);
      l2c4 <= l2s_ext * c3_ext;
      c4   <= c3;
      unr4 <= unr3;
      x4   <= x3;
      y4   <= y3;
    end
  end

  // Stage 5: radicand d^2 - c^2 and l1*d + l2*c
  always_ff @(posedge clk) begin
    if (adv) begin
      rad5 <= dsq4 - csq4;
      t5   <= TW'(signed'({1'b0, l1d4})) + l2c4;
      c5   <= c4;
      unr5 <= unr4;
      x5   <= x4;
      y5   <= y4;
    end
  end

  // Square root, one result bit per stage
  logic [SQW-1:0]        sv  [0:STEPS];
  logic [SQW-1:0]        sr  [0:STEPS];
  logic signed [CB-1:0]  qxa [0:STEPS];
  logic signed [CB-1:0]  qya [0:STEPS];
  logic signed [CWD-1:0] qc  [0:STEPS];
  logic signed [TW-1:0]  qt  [0:STEPS];
  logic                  qu  [0:STEPS];
  logic                  qv  [0:STEPS];

  assign sv[0]  = rad5;
  assign sr[0]  = '0;
  assign qxa[0] = x5;
  assign qya[0] = y5;
  assign qc[0]  = c5;
  assign qt[0]  = t5;
  assign qu[0]  = unr5;
  assign qv[0]  = v5;

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam int BP = 2 * (STEPS - 1 - k);
    logic [SQW-1:0] trial;
    assign trial = sr[k] + (SQW'(1) << BP);
    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k+1] <= 1'b0;
      end else if (adv) begin
        qv[k+1] <= qv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sv[k] >= trial) begin
          sv[k+1] <= sv[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + (SQW'(1) << BP);
        end else begin
          sv[k+1] <= sv[k];
          sr[k+1] <= sr[k] >> 1;
        end
        qxa[k+1] <= qxa[k];
        qya[k+1] <= qya[k];
        qc[k+1]  <= qc[k];
        qt[k+1]  <= qt[k];
        qu[k+1]  <= qu[k];
      end
    end
  end

  // Stage 6: l2*s and |l1*d + l2*c|
  logic [DW-1:0]  s_root;
  logic [PW-1:0]  ls6;
  logic [TW-1:0]  at6;
  logic [DW-1:0]  s6;
  logic signed [CWD-1:0] c6;
  logic signed [CB-1:0]  x6, y6;
  logic v6, unr6;
  logic signed [TW-1:0] tq;
  assign s_root = sr[STEPS][DW-1:0];
  assign tq     = qt[STEPS];
  always_ff @(posedge clk) begin
    if (adv) begin
      ls6  <= PW'(lower_len) * PW'(s_root);
      at6  <= tq[TW-1] ? TW'(-tq) : TW'(tq);
      s6   <= s_root;
      c6   <= qc[STEPS];
      x6   <= qxa[STEPS];
      y6   <= qya[STEPS];
      unr6 <= qu[STEPS];
    end
  end

  // Three arctangents in parallel
  logic signed [ZW-1:0] za, zb, zc;

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_atan_target (
    .clk   (clk),
    .en    (adv),
    .in_y  (CW'(y6)),
    .in_x  (CW'(x6)),
    .angle (za)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_atan_elbow (
    .clk   (clk),
    .en    (adv),
    .in_y  (CW'(signed'({1'b0, s6}))),
    .in_x  (CW'(c6)),
    .angle (zb)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_atan_psi (
    .clk   (clk),
    .en    (adv),
    .in_y  (CW'(signed'({1'b0, ls6}))),
    .in_x  (CW'(signed'({1'b0, at6}))),
    .angle (zc)
  );

  // Valid and reach flag travel alongside the CORDIC stages
  logic du [0:LAT_C];
  logic dv [0:LAT_C];
  assign du[0] = unr6;
  assign dv[0] = v6;
  for (genvar n = 0; n < LAT_C; n++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[n+1] <= 1'b0;
      end else if (adv) begin
        dv[n+1] <= dv[n];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        du[n+1] <= du[n];
      end
    end
  end

  // Front valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= qv[STEPS];
    end
  end

  // Final stage A: shoulder difference and rounding offset
  localparam logic signed [SW-1:0] ROUND = SW'(1) <<< (Q12_SHIFT - 1);
  logic signed [SW-1:0] shs, els;
  logic vf, unrf;
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (adv) begin
      vf <= dv[LAT_C];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      shs  <= SW'(za) - SW'(zc) + ROUND;
      els  <= SW'(zb) + ROUND;
      unrf <= du[LAT_C];
    end
  end

  // Final stage B: shift to Q12, clamp, output register
  logic signed [QW-1:0] shq, elq;
  logic signed [15:0]   sh_clamp;
  logic [13:0]          el_clamp;
  assign shq = shs[SW-1:Q12_SHIFT];
  assign elq = els[SW-1:Q12_SHIFT];

  always_comb begin
    priority if (shq > QW'(SHOULDER_MAX)) begin
      sh_clamp = 16'(SHOULDER_MAX);
    end else if (shq < -QW'(SHOULDER_MAX)) begin
      sh_clamp = -16'(SHOULDER_MAX);
    end else begin
      sh_clamp = 16'(shq);
    end
    priority if (elq[QW-1]) begin
      el_clamp = '0;
    end else if (elq > QW'(ELBOW_MAX)) begin
      el_clamp = 14'(ELBOW_MAX);
    end else begin
      el_clamp = 14'(elq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unreachable    <= unrf;
      shoulder_angle <= unrf ? '0 : sh_clamp;
      elbow_angle    <= unrf ? '0 : el_clamp;
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tlik_pkg::*;

  localparam int STAGES   = 16;
  localparam int PIPE_LAT = 47 + STAGES;
  localparam longint NORM = 64'sd1 << 40;

  typedef struct packed {
    logic signed [15:0] shoulder;
    logic [13:0]        elbow;
    logic               unreach;
  } joint_angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] target_x = '0;
  logic signed [15:0] target_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] shoulder_angle;
  logic [13:0] elbow_angle;
  logic unreachable;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [LINK_W-1:0] cfg_data = '0;

  // Local copy of the link length registers
  longint upper_len = 3277;
  longint lower_len = 1638;
  bit calm = 1'b0;
  int errors = 0;
  joint_angles_t pending_angles[$];

  // atan(2^-i) in Q30, truncated
  longint atan_tab[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127};

  two_link_inverse_kinematics u_dut (.*);

  always #6 clk = ~clk;

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Vectoring CORDIC, result in Q30 radians
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (abs64(x) < NORM && abs64(y) < NORM) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(HALF_PI_Q30);
      end else begin
        x = -y; y = t; z = -longint'(HALF_PI_Q30);
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint root_floor(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic joint_angles_t solve_joints(longint x, longint y);
    joint_angles_t r;
    longint l1, l2, r2, sum, dif, c, d, s, elbow, shoulder;
    l1 = upper_len;
    l2 = lower_len;
    r2 = x * x + y * y;
    sum = l1 + l2;
    dif = abs64(l1 - l2);
    r = '{shoulder: '0, elbow: '0, unreach: 1'b1};
    if (l1 == 0 || l2 == 0 || r2 == 0 || r2 > sum * sum || r2 < dif * dif) return r;
    c = r2 - l1 * l1 - l2 * l2;
    d = 2 * l1 * l2;
    s = root_floor(64'(d * d - c * c));
    elbow = (vector_angle(s, c) + (64'sd1 << 17)) >>> Q12_SHIFT;
    if (elbow < 0) elbow = 0;
    if (elbow > ELBOW_MAX) elbow = ELBOW_MAX;
    shoulder = (vector_angle(y, x) - vector_angle(l2 * s, abs64(l1 * d + l2 * c))
                + (64'sd1 << 17)) >>> Q12_SHIFT;
    if (shoulder > SHOULDER_MAX) shoulder = SHOULDER_MAX;
    if (shoulder < -SHOULDER_MAX) shoulder = -SHOULDER_MAX;
    r.shoulder = shoulder[15:0];
    r.elbow = elbow[13:0];
    r.unreach = 1'b0;
    return r;
  endfunction

  // Send one target; the expectation is queued at acceptance
  task automatic send_target(int x, int y);
    in_valid <= 1'b1;
    target_x <= x[15:0];
    target_y <= y[15:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_angles.push_back(solve_joints(longint'(signed'(x[15:0])),
                                          longint'(signed'(y[15:0]))));
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Drop valid at once so the last target is not taken twice
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty
  task automatic write_len(cfg_reg_t idx, int val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[LINK_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_UPPER_LEN) upper_len = val & 32'h7FFF;
    else lower_len = val & 32'h7FFF;
  endtask

  // Output channel stall bursts
  initial begin
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    joint_angles_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = pending_angles.pop_front();
        if (shoulder_angle !== e.shoulder) begin
          $error("shoulder_angle: expected %0d, got %0d", e.shoulder, shoulder_angle);
          errors++;
        end
        if (elbow_angle !== e.elbow) begin
          $error("elbow_angle: expected %0d, got %0d", e.elbow, elbow_angle);
          errors++;
        end
        if (unreachable !== e.unreach) begin
          $error("unreachable: expected %0b, got %0b", e.unreach, unreachable);
          errors++;
        end
      end
    end
  end

  // Reset lengths: origin, annulus edges, axis crossings, coordinate extremes
  task automatic test_reset_lengths();
    send_target(0, 0);
    send_target(4915, 0);
    send_target(4916, 0);
    send_target(1639, 0);
    send_target(1638, 0);
    send_target(-4915, 0);
    send_target(0, -3000);
    send_target(3000, 2000);
    send_target(-3000, 1000);
    send_target(-1000, -3000);
    send_target(-32768, -32768);
    send_target(32767, 32767);
    send_target(-32768, 0);
  endtask

  // A zero-length link makes every target unreachable
  task automatic test_zero_link();
    write_len(REG_UPPER_LEN, 0);
    send_target(1638, 0);
    send_target(0, 0);
    write_len(REG_UPPER_LEN, 3277);
    write_len(REG_LOWER_LEN, 0);
    send_target(3277, 0);
  endtask

  task automatic test_extreme_lengths();
    write_len(REG_UPPER_LEN, 32767);
    write_len(REG_LOWER_LEN, 32767);
    send_target(-32768, -32768);
    send_target(32767, -1);
    send_target(1, 0);
    write_len(REG_UPPER_LEN, 1);
    write_len(REG_LOWER_LEN, 1);
    send_target(2, 0);
    send_target(0, -1);
    send_target(1, 1);
    send_target(3, 0);
  endtask

  // Random phase: mostly targets inside the annulus, the rest anywhere
  task automatic test_random_phase(int n, int l1, int l2);
    int x, y, span, tries;
    longint r2, sum, dif;
    write_len(REG_UPPER_LEN, l1);
    write_len(REG_LOWER_LEN, l2);
    sum = l1 + l2;
    dif = (l1 > l2) ? l1 - l2 : l2 - l1;
    span = (sum > 32767) ? 32767 : int'(sum);
    for (int k = 0; k < n; k++) begin
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 99) < 85) begin
        tries = 0;
        do begin
          x = int'($urandom_range(0, 2 * span)) - span;
          y = int'($urandom_range(0, 2 * span)) - span;
          r2 = longint'(x) * x + longint'(y) * y;
          tries++;
        end while ((r2 == 0 || r2 > sum * sum || r2 < dif * dif) && tries < 40);
      end
      send_target(x, y);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_lengths();
    test_zero_link();
    test_extreme_lengths();
    test_random_phase(200, 3277, 1638);
    test_random_phase(200, 32767, 32767);
    test_random_phase(150, 1, 32767);
    test_random_phase(200, $urandom_range(500, 20000), $urandom_range(500, 20000));
    test_random_phase(200, $urandom_range(1, 32767), $urandom_range(1, 32767));
    test_random_phase(200, $urandom_range(2000, 16000), $urandom_range(100, 8000));
    test_random_phase(200, $urandom_range(100, 8000), $urandom_range(2000, 16000));
    calm = 1'b1;
    test_random_phase(250, $urandom_range(1000, 16000), $urandom_range(1000, 16000));
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(12 * 800000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
